@@ rtl/msr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package msr_pkg;

   // Handshake between the sequencer and the shared modular multiplier.
   typedef struct packed {
      logic busy;
      logic done;
   } mm_stat_type;

   // Result status codes.
   localparam logic STATUS_ROOT   = 1'b0;
   localparam logic STATUS_NONRES = 1'b1;

   // The non-residue search stops before this candidate.
   localparam int unsigned NR_STOP = 1026;
   localparam int unsigned Z_BITS  = 11;

endpackage

`default_nettype wire

@@ rtl/modular_square_root.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Ports                        Contents
// request   in         req_tvalid/tready/tdata      value, modulus
// response  out        rsp_tvalid/tready/tdata/tuser root, status
//
// One modular exponentiation takes up to 2*(MOD_BITS-1) multiplications on the shared
// bit-serial unit. How long an item takes is set by the exponentiations, the non-residue
// search and the squaring loop; a modulus of two or below skips all of them. Reset is
// synchronous and clears the sequencer and the output valid. A new transaction is accepted
// only while the sequencer is idle; a finished result waits in the output register, and the
// sequencer can hold a second one.
module modular_square_root
   import msr_pkg::*;
#(
   parameter int MOD_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // value [31:0], modulus [63:32]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // root [31:0]
   output logic             rsp_tuser    // status [0]
);

   localparam int W  = MOD_BITS;
   localparam int CW = $clog2(W + 1);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_RED   = 5'd1;
   localparam logic [4:0] S_EUL   = 5'd2;
   localparam logic [4:0] S_QS    = 5'd3;
   localparam logic [4:0] S_ZTEST = 5'd4;
   localparam logic [4:0] S_ZCHK  = 5'd5;
   localparam logic [4:0] S_GC    = 5'd6;
   localparam logic [4:0] S_GT    = 5'd7;
   localparam logic [4:0] S_GR    = 5'd8;
   localparam logic [4:0] S_LOOP  = 5'd9;
   localparam logic [4:0] S_SQ    = 5'd10;
   localparam logic [4:0] S_SQR   = 5'd11;
   localparam logic [4:0] S_BSQ   = 5'd12;
   localparam logic [4:0] S_BSQR  = 5'd13;
   localparam logic [4:0] S_C2    = 5'd14;
   localparam logic [4:0] S_T2    = 5'd15;
   localparam logic [4:0] S_R2    = 5'd16;
   localparam logic [4:0] S_PCHK  = 5'd17;
   localparam logic [4:0] S_PA    = 5'd18;
   localparam logic [4:0] S_PB    = 5'd19;
   localparam logic [4:0] S_MWAIT = 5'd20;
   localparam logic [4:0] S_EMIT  = 5'd21;
   localparam logic [4:0] S_PROOT = 5'd22;

   logic [4:0]        state_ff, state_in;
   logic [4:0]        mret_ff, mret_in;
   logic [4:0]        pret_ff, pret_in;
   logic [W-1:0]      p_ff, p_in;
   logic [W-1:0]      n_ff, n_in;
   logic [W-1:0]      q_ff, q_in;
   logic [CW-1:0]     s_ff, s_in;
   logic [CW-1:0]     m_ff, m_in;
   logic [CW-1:0]     i_ff, i_in;
   logic [CW-1:0]     j_ff, j_in;
   logic [Z_BITS-1:0] z_ff, z_in;
   logic [W-1:0]      c_ff, c_in;
   logic [W-1:0]      t_ff, t_in;
   logic [W-1:0]      r_ff, r_in;
   logic [W-1:0]      sq_ff, sq_in;
   logic [W-1:0]      b_ff, b_in;
   logic [W-1:0]      pbase_ff, pbase_in;
   logic [W-1:0]      pexp_ff, pexp_in;
   logic [W-1:0]      pacc_ff, pacc_in;
   logic [W-1:0]      mul_a_ff, mul_a_in;
   logic [W-1:0]      mul_b_ff, mul_b_in;
   logic              mm_go_ff, mm_go_in;
   logic [W-1:0]      fin_root_ff, fin_root_in;
   logic              fin_stat_ff, fin_stat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_root_ff, rsp_root_in;
   logic              rsp_stat_ff, rsp_stat_in;

   mm_stat_type  mm_stat;
   logic [W-1:0] mm_res;

   logic [W-1:0]  req_value, req_mod;
   logic [W-1:0]  pm1;
   logic [W:0]    p_plus, q_plus;
   logic [31:0]   lim;
   logic [CW:0]   jsum;

   msr_mulmod #(.W(W)) u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (mm_go_ff),
      .a      (mul_a_ff),
      .b      (mul_b_ff),
      .p      (p_ff),
      .stat   (mm_stat),
      .result (mm_res)
   );

   always_comb begin
      req_value = req_tdata[W-1:0];
      req_mod   = req_tdata[32 +: W];
      pm1       = p_ff - 1'b1;
      p_plus    = {1'b0, p_ff} + 1'b1;
      q_plus    = {1'b0, q_ff} + 1'b1;
      lim       = (32'(pm1) < NR_STOP) ? 32'(pm1) : NR_STOP;
      jsum      = {1'b0, j_ff} + {1'b0, i_ff} + 1'b1;
   end

   always_comb begin
      state_in     = state_ff;
      mret_in      = mret_ff;
      pret_in      = pret_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      q_in         = q_ff;
      s_in         = s_ff;
      m_in         = m_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      z_in         = z_ff;
      c_in         = c_ff;
      t_in         = t_ff;
      r_in         = r_ff;
      sq_in        = sq_ff;
      b_in         = b_ff;
      pbase_in     = pbase_ff;
      pexp_in      = pexp_ff;
      pacc_in      = pacc_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      mm_go_in     = 1'b0;
      fin_root_in  = fin_root_ff;
      fin_stat_in  = fin_stat_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_root_in  = rsp_root_ff;
      rsp_stat_in  = rsp_stat_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               p_in        = req_mod;
               n_in        = req_value;
               fin_root_in = '0;
               fin_stat_in = STATUS_ROOT;
               if (req_mod < W'(2)) begin
                  state_in = S_EMIT;
               end else if (req_mod == W'(2)) begin
                  fin_root_in = W'(req_value[0]);
                  state_in    = S_EMIT;
               end else begin
                  // Reduce the value as value * 1 mod p.
                  mul_a_in = req_value;
                  mul_b_in = W'(1);
                  mm_go_in = 1'b1;
                  mret_in  = S_RED;
                  state_in = S_MWAIT;
               end
            end
         end
         S_RED: begin
            n_in = mm_res;
            if (mm_res == '0) begin
               state_in = S_EMIT;
            end else begin
               pbase_in = mm_res;
               pexp_in  = pm1 >> 1;
               pacc_in  = W'(1);
               pret_in  = S_EUL;
               state_in = S_PCHK;
            end
         end
         S_EUL: begin
            if (pacc_ff != W'(1)) begin
               fin_stat_in = STATUS_NONRES;
               state_in    = S_EMIT;
            end else if (p_ff[1:0] == 2'b11) begin
               pbase_in = n_ff;
               pexp_in  = {1'b0, p_plus[W:2]};
               pacc_in  = W'(1);
               pret_in  = S_PROOT;
               state_in = S_PCHK;
            end else begin
               q_in     = pm1;
               s_in     = '0;
               state_in = S_QS;
            end
         end
         S_PROOT: begin
            fin_root_in = pacc_ff;
            state_in    = S_EMIT;
         end
         S_QS: begin
            if (!q_ff[0]) begin
               q_in = q_ff >> 1;
               s_in = s_ff + 1'b1;
            end else begin
               z_in     = Z_BITS'(2);
               state_in = S_ZTEST;
            end
         end
         S_ZTEST: begin
            if (32'(z_ff) < lim) begin
               pbase_in = W'(z_ff);
               pexp_in  = pm1 >> 1;
               pacc_in  = W'(1);
               pret_in  = S_ZCHK;
               state_in = S_PCHK;
            end else begin
               fin_stat_in = STATUS_NONRES;
               state_in    = S_EMIT;
            end
         end
         S_ZCHK: begin
            if (pacc_ff == pm1) begin
               m_in     = s_ff;
               pbase_in = W'(z_ff);
               pexp_in  = q_ff;
               pacc_in  = W'(1);
               pret_in  = S_GC;
               state_in = S_PCHK;
            end else begin
               z_in     = z_ff + 1'b1;
               state_in = S_ZTEST;
            end
         end
         S_GC: begin
            c_in     = pacc_ff;
            pbase_in = n_ff;
            pexp_in  = q_ff;
            pacc_in  = W'(1);
            pret_in  = S_GT;
            state_in = S_PCHK;
         end
         S_GT: begin
            t_in     = pacc_ff;
            pbase_in = n_ff;
            pexp_in  = q_plus[W:1];
            pacc_in  = W'(1);
            pret_in  = S_GR;
            state_in = S_PCHK;
         end
         S_GR: begin
            r_in     = pacc_ff;
            state_in = S_LOOP;
         end
         S_LOOP: begin
            if (t_ff == W'(1)) begin
               fin_root_in = r_ff;
               state_in    = S_EMIT;
            end else begin
               i_in     = '0;
               sq_in    = t_ff;
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (sq_ff != W'(1) && i_ff < m_ff) begin
               mul_a_in = sq_ff;
               mul_b_in = sq_ff;
               mm_go_in = 1'b1;
               mret_in  = S_SQR;
               state_in = S_MWAIT;
            end else if (i_ff >= m_ff) begin
               fin_stat_in = STATUS_NONRES;
               state_in    = S_EMIT;
            end else begin
               b_in     = c_ff;
               j_in     = '0;
               state_in = S_BSQ;
            end
         end
         S_SQR: begin
            sq_in    = mm_res;
            i_in     = i_ff + 1'b1;
            state_in = S_SQ;
         end
         S_BSQ: begin
            mul_a_in = b_ff;
            mul_b_in = b_ff;
            mm_go_in = 1'b1;
            state_in = S_MWAIT;
            if (jsum < {1'b0, m_ff}) begin
               mret_in = S_BSQR;
            end else begin
               m_in    = i_ff;
               mret_in = S_C2;
            end
         end
         S_BSQR: begin
            b_in     = mm_res;
            j_in     = j_ff + 1'b1;
            state_in = S_BSQ;
         end
         S_C2: begin
            c_in     = mm_res;
            mul_a_in = t_ff;
            mul_b_in = mm_res;
            mm_go_in = 1'b1;
            mret_in  = S_T2;
            state_in = S_MWAIT;
         end
         S_T2: begin
            t_in     = mm_res;
            mul_a_in = r_ff;
            mul_b_in = b_ff;
            mm_go_in = 1'b1;
            mret_in  = S_R2;
            state_in = S_MWAIT;
         end
         S_R2: begin
            r_in     = mm_res;
            state_in = S_LOOP;
         end
         S_PCHK: begin
            if (pexp_ff == '0) begin
               state_in = pret_ff;
            end else begin
               mm_go_in = 1'b1;
               state_in = S_MWAIT;
               if (pexp_ff[0]) begin
                  mul_a_in = pacc_ff;
                  mul_b_in = pbase_ff;
                  mret_in  = S_PA;
               end else begin
                  mul_a_in = pbase_ff;
                  mul_b_in = pbase_ff;
                  mret_in  = S_PB;
               end
            end
         end
         S_PA: begin
            pacc_in  = mm_res;
            mul_a_in = pbase_ff;
            mul_b_in = pbase_ff;
            mm_go_in = 1'b1;
            mret_in  = S_PB;
            state_in = S_MWAIT;
         end
         S_PB: begin
            pbase_in = mm_res;
            pexp_in  = pexp_ff >> 1;
            state_in = S_PCHK;
         end
         S_MWAIT: begin
            if (mm_stat.done && !mm_stat.busy) begin
               state_in = mret_ff;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_root_in  = 32'(fin_root_ff);
               rsp_stat_in  = fin_stat_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mm_go_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mm_go_ff     <= mm_go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mret_ff     <= mret_in;
      pret_ff     <= pret_in;
      p_ff        <= p_in;
      n_ff        <= n_in;
      q_ff        <= q_in;
      s_ff        <= s_in;
      m_ff        <= m_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      z_ff        <= z_in;
      c_ff        <= c_in;
      t_ff        <= t_in;
      r_ff        <= r_in;
      sq_ff       <= sq_in;
      b_ff        <= b_in;
      pbase_ff    <= pbase_in;
      pexp_ff     <= pexp_in;
      pacc_ff     <= pacc_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      fin_root_ff <= fin_root_in;
      fin_stat_ff <= fin_stat_in;
      rsp_root_ff <= rsp_root_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_root_ff;
   assign rsp_tuser  = rsp_stat_ff;

endmodule

`default_nettype wire

@@ rtl/msr_mulmod.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Interleaved shift-and-add modular multiplier: one multiplier bit per cycle,
// most significant bit first. The multiplicand must be below the modulus.
module msr_mulmod
   import msr_pkg::*;
#(
   parameter int W = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] a,
   input  wire logic [W-1:0] b,
   input  wire logic [W-1:0] p,
   output mm_stat_type       stat,
   output logic      [W-1:0] result
);

   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  a_ff, a_in;
   logic [W-1:0]  b_ff, b_in;
   logic [W-1:0]  acc_ff, acc_in;

   logic [W:0] dbl, dbl_red, sum, sum_red;

   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, p}) ? dbl - {1'b0, p} : dbl;
      sum     = dbl_red + (a_ff[W-1] ? {1'b0, b_ff} : '0);
      sum_red = (sum >= {1'b0, p}) ? sum - {1'b0, p} : sum;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = sum_red[W-1:0];
         a_in   = {a_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = acc_ff;

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import msr_pkg::*;

   localparam int  HALF_PERIOD = 10;
   localparam int  NUM_RANDOM  = 150;
   localparam longint CYCLE_LIMIT = 400_000_000;
   localparam int  DRAIN_CYCLES = 20_000;
   localparam int  LONG_HOLD = 600_000;

   typedef struct {
      logic [31:0] value;
      logic [31:0] modulus;
      bit          drain_first;   // wait until every response is back
   } sqrt_req_type;

   typedef struct {
      logic [31:0] root;
      logic        status;
   } sqrt_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;      // value [31:0], modulus [63:32]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // root [31:0]
   logic        rsp_tuser;          // status [0]

   sqrt_req_type pending_reqs[$];
   sqrt_rsp_type expected_roots[$];
   int          error_count = 0;
   longint      cycle_count = 0;
   int          accepted_reqs = 0;
   int          hold_cycles = 0;
   bit          hold_started = 1'b0;
   bit          req_taken = 1'b0;
   bit          stimulus_done = 1'b0;

   modular_square_root #(.MOD_BITS(32)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------
   // Arithmetic helpers for the prediction. All operands are below 2^32,
   // so a 64-bit product never overflows.
   // ------------------------------------------------------------------
   function automatic longint unsigned mul_mod_p(longint unsigned a, longint unsigned b,
                                                 longint unsigned p);
      return (a * b) % p;
   endfunction

   function automatic longint unsigned pow_mod_p(longint unsigned base, longint unsigned e,
                                                 longint unsigned p);
      longint unsigned acc;
      acc  = 1 % p;
      base = base % p;
      while (e != 0) begin
         if (e[0]) acc = mul_mod_p(acc, base, p);
         base = mul_mod_p(base, base, p);
         e = e >> 1;
      end
      return acc;
   endfunction

   // Deterministic Miller-Rabin; bases 2, 7 and 61 cover every 32-bit number.
   function automatic bit is_prime(longint unsigned n);
      longint unsigned bases[3];
      longint unsigned d, x;
      int              s;
      bit              witness_ok;
      bases = '{2, 7, 61};
      if (n < 2) return 1'b0;
      if (n % 2 == 0) return n == 2;
      for (int k = 0; k < 3; k++) begin
         if (bases[k] % n == 0) continue;
         d = n - 1;
         s = 0;
         while (d[0] == 1'b0) begin
            d = d >> 1;
            s++;
         end
         x = pow_mod_p(bases[k], d, n);
         if (x == 1 || x == n - 1) continue;
         witness_ok = 1'b0;
         for (int j = 1; j < s; j++) begin
            x = mul_mod_p(x, x, n);
            if (x == n - 1) begin
               witness_ok = 1'b1;
               break;
            end
         end
         if (!witness_ok) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic longint unsigned prime_at_or_below(longint unsigned n);
      if (n < 2) n = 2;
      while (!is_prime(n)) n--;
      return n;
   endfunction

   // Prediction of one response: Euler's criterion first, then either the
   // direct power for p = 3 mod 4 or the Tonelli-Shanks loop.
   function automatic sqrt_rsp_type predict_root(logic [31:0] value, logic [31:0] modulus);
      sqrt_rsp_type    res;
      longint unsigned n, p, q, s, z, m, c, t, r, lim, i, sq, b;
      bit              got;
      n = value;
      p = modulus;
      res.root   = '0;
      res.status = STATUS_ROOT;
      got = 1'b0;
      if (p < 2) return res;
      if (p == 2) begin
         res.root = {31'b0, value[0]};
         return res;
      end
      n = n % p;
      if (n == 0) return res;
      if (pow_mod_p(n, (p - 1) / 2, p) != 1) begin
         res.status = STATUS_NONRES;
         return res;
      end
      if ((p & 3) == 3) begin
         res.root = 32'(pow_mod_p(n, (p + 1) / 4, p));
         return res;
      end
      q = p - 1;
      s = 0;
      while (q != 0 && q[0] == 1'b0) begin
         q = q >> 1;
         s++;
      end
      lim = (p - 1 < NR_STOP) ? p - 1 : NR_STOP;
      z = 2;
      while (z < lim) begin
         if (pow_mod_p(z, (p - 1) / 2, p) == p - 1) begin
            got = 1'b1;
            break;
         end
         z++;
      end
      if (!got) begin
         res.status = STATUS_NONRES;
         return res;
      end
      m = s;
      c = pow_mod_p(z, q, p);
      t = pow_mod_p(n, q, p);
      r = pow_mod_p(n, (q + 1) / 2, p);
      forever begin
         if (t == 1) begin
            res.root = 32'(r);
            return res;
         end
         i  = 0;
         sq = t;
         while (sq != 1 && i < m) begin
            sq = mul_mod_p(sq, sq, p);
            i++;
         end
         if (i >= m) begin
            res.status = STATUS_NONRES;
            return res;
         end
         b = c;
         for (longint unsigned j = 0; j + i + 1 < m; j++) b = mul_mod_p(b, b, p);
         m = i;
         c = mul_mod_p(b, b, p);
         t = mul_mod_p(t, c, p);
         r = mul_mod_p(r, b, p);
      end
   endfunction

   task automatic add_req(longint unsigned value, longint unsigned modulus, bit drain);
      sqrt_req_type item;
      item.value       = 32'(value);
      item.modulus     = 32'(modulus);
      item.drain_first = drain;
      pending_reqs.push_back(item);
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at cycle %0d: %s got 0x%08h expected 0x%08h",
               cycle_count, what, got, want);
      error_count++;
   endtask

   // ------------------------------------------------------------------
   // Stimulus. The directed part covers modulus two, tiny primes, a value
   // that is a multiple of the modulus, non-residues, and large primes of
   // both classes mod 4, including one with a long power-of-two in p - 1.
   // ------------------------------------------------------------------
   initial begin
      longint unsigned p_big3, p_big1, p_ntt, p, r, v, span;
      int              bits;
      p_big3 = prime_at_or_below(64'hFFFF_FFFF);
      p_ntt  = prime_at_or_below(64'd3221225473);
      p_big1 = 64'hFFFF_FFF1;
      while (!is_prime(p_big1) || (p_big1 & 7) != 1) p_big1 = p_big1 - 8;

      add_req(0, 2, 1'b0);
      add_req(1, 2, 1'b0);
      add_req(64'hFFFF_FFFF, 2, 1'b0);
      add_req(64'hFFFF_FFFE, 2, 1'b0);
      add_req(0, 3, 1'b0);
      add_req(1, 3, 1'b0);
      add_req(2, 3, 1'b0);
      add_req(4, 5, 1'b0);
      add_req(2, 5, 1'b0);
      add_req(2, 17, 1'b0);
      add_req(13, 17, 1'b0);
      add_req(51, 17, 1'b0);
      add_req(64'hFFFF_FFFF, p_big3, 1'b0);
      add_req(4, p_big3, 1'b0);
      add_req(p_big3, p_big3, 1'b0);
      add_req(64'hFFFF_FFFF, p_ntt, 1'b0);
      add_req(mul_mod_p(64'h1234_5678, 64'h1234_5678, p_ntt), p_ntt, 1'b0);
      add_req(mul_mod_p(64'hDEAD_BEEF, 64'hDEAD_BEEF, p_big1), p_big1, 1'b0);
      add_req(64'hAAAA_AAAA, p_big1, 1'b0);
      add_req(64'h5555_5555, 64'd97, 1'b0);

      for (int k = 0; k < NUM_RANDOM; k++) begin
         // Mostly short moduli keep the run quick; some use the full width.
         bits = ($urandom_range(0, 3) == 0) ? 32 : $urandom_range(2, 31);
         p = prime_at_or_below({32'b0, $urandom} & ((64'd1 << bits) - 1));
         if ($urandom_range(0, 19) == 0) p = 2;
         if ($urandom_range(0, 9) < 7) begin
            r = $urandom;
            v = mul_mod_p(r, r, p);
         end else begin
            v = $urandom % p;
         end
         // Often lift the value by a multiple of p to exercise the reduction.
         if ($urandom_range(0, 1) == 1) begin
            span = (64'hFFFF_FFFF - v) / p;
            v = v + p * ({32'b0, $urandom} % (span + 1));
         end
         if ($urandom_range(0, 29) == 0) v = $urandom;
         add_req(v, p, k == 60);
      end
      stimulus_done = 1'b1;
   end

   // Reset at the start, released on a falling edge.
   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Idling phase from how far the run has come: none, sender idle,
   // receiver stalling, both.
   function automatic int phase_now();
      return (accepted_reqs / 20) % 4;
   endfunction

   // ------------------------------------------------------------------
   // Driver: changes the request channel at the falling edge. A held
   // request stays put until the monitor has seen it accepted.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      logic         next_valid;
      logic [63:0]  next_data;
      sqrt_req_type item;
      int           ph;
      next_valid = req_tvalid;
      next_data  = req_tdata;
      ph = phase_now();
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_tvalid || req_taken) begin
         next_valid = 1'b0;
         if (pending_reqs.size() != 0) begin
            item = pending_reqs[0];
            if (item.drain_first && expected_roots.size() != 0) begin
               next_valid = 1'b0;
            end else if ((ph == 1 || ph == 3) &&
                         $urandom_range(0, 99) < ((ph == 1) ? 47 : 14)) begin
               next_valid = 1'b0;
            end else begin
               item = pending_reqs.pop_front();
               next_valid = 1'b1;
               next_data  = {item.modulus, item.value};
            end
         end
      end
      req_taken  = 1'b0;
      req_tvalid <= next_valid;
      req_tdata  <= next_data;
   end

   // Receiver: random stalls per phase, plus one long hold-off while the
   // sender keeps offering, so the block backs up and stalls its input.
   always @(negedge clock) begin
      logic next_ready;
      int   ph;
      ph = phase_now();
      if (reset) begin
         next_ready = 1'b0;
      end else if (hold_cycles > 0) begin
         next_ready = 1'b0;
         hold_cycles = hold_cycles - 1;
      end else if (!hold_started && accepted_reqs == 30) begin
         hold_started = 1'b1;
         hold_cycles = LONG_HOLD;
         next_ready = 1'b0;
      end else if ((ph == 2 || ph == 3) &&
                   $urandom_range(0, 99) < ((ph == 2) ? 47 : 14)) begin
         next_ready = 1'b0;
      end else begin
         next_ready = 1'b1;
      end
      rsp_tready <= next_ready;
   end

   // ------------------------------------------------------------------
   // Monitor: samples both channels at the rising edge. An accepted
   // request gets its prediction queued; a response is checked against
   // the oldest one.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      sqrt_rsp_type want;
      cycle_count++;
      if (!reset && req_tvalid && req_tready) begin
         req_taken = 1'b1;
         accepted_reqs++;
         expected_roots.push_back(predict_root(req_tdata[31:0], req_tdata[63:32]));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_roots.size() == 0) begin
            report_mismatch("unexpected response root", rsp_tdata, 32'h0);
         end else begin
            want = expected_roots.pop_front();
            if (rsp_tdata !== want.root) report_mismatch("root", rsp_tdata, want.root);
            if (rsp_tuser !== want.status)
               report_mismatch("status", {31'b0, rsp_tuser}, {31'b0, want.status});
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // End of run: all requests sent and answered, then a quiet stretch to
   // catch any stray response.
   initial begin
      wait (stimulus_done);
      @(posedge clock);
      while (pending_reqs.size() != 0 || req_tvalid || expected_roots.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_roots.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ modular_square_root.f @@
rtl/msr_pkg.sv
rtl/msr_mulmod.sv
rtl/modular_square_root.sv
tb/sv/testbench.sv
